// File: sv/k_nearest_candidate_list_defines.svh
// Assertion macros used by the checker file of the candidate list.
`ifndef K_NEAREST_CANDIDATE_LIST_DEFINES_SVH
`define K_NEAREST_CANDIDATE_LIST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KNCL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("candidate list check failed");

// The consequent must hold in the cycle after the antecedent.
`define KNCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("candidate list check failed");

`endif

// File: sv/kncl_pkg.sv
`default_nettype none

package kncl_pkg;

  localparam int unsigned KNCL_MAX_NEIGHBORS = 32;

  localparam int unsigned INDEX_W = 20;
  localparam int unsigned DIST_W  = 48;
  localparam int unsigned RANK_W  = 5;
  localparam int unsigned COUNT_W = 6;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic REG_CAPACITY      = 1'b0;
  localparam logic REG_SORTED_OUTPUT = 1'b1;

  localparam logic [5:0] CAPACITY_RESET      = 6'd32;
  localparam logic       SORTED_OUTPUT_RESET = 1'b1;

  typedef struct packed {
    logic [INDEX_W-1:0] point_index;
    logic [DIST_W-1:0]  distance_sq;
    logic               query_start;
    logic               query_end;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] result_index;
    logic [DIST_W-1:0]  result_dist_sq;
    logic [RANK_W-1:0]  result_rank;
    logic [COUNT_W-1:0] result_count;
    logic               last_result;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/k_nearest_candidate_list.sv
// Flow: a candidate is registered at acceptance and merged into the list from that register;
// at a query end, the list goes to a snapshot register, then its first result to the output.
// Throughput: one candidate per cycle unless stalled; a query end emits every kept entry,
// and a further end-of-query candidate waits until the previous list reaches its last beat.
// Reset (synchronous, rst_n low): list empty, no beats pending, capacity 32, nearest first.
`default_nettype none

module k_nearest_candidate_list import kncl_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = KNCL_MAX_NEIGHBORS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

  logic [5:0] capacity_r;
  logic       sorted_output_r;
  logic       cfg_wr;

  logic     stage_valid_r;
  in_item_t stage_r;
  logic     stage_go;

  logic [INDEX_W-1:0] kept_idx_r  [MAX_NEIGHBORS];
  logic [DIST_W-1:0]  kept_dist_r [MAX_NEIGHBORS];
  logic [INDEX_W-1:0] kept_idx_nxt  [MAX_NEIGHBORS];
  logic [DIST_W-1:0]  kept_dist_nxt [MAX_NEIGHBORS];
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   fill_nxt;

  logic [CNT_W-1:0]         limit;
  logic [CNT_W-1:0]         n_now;
  logic                     full;
  logic [MAX_NEIGHBORS-1:0] ge;

  logic [INDEX_W-1:0] snap_idx_r  [MAX_NEIGHBORS];
  logic [DIST_W-1:0]  snap_dist_r [MAX_NEIGHBORS];
  logic [CNT_W-1:0]   snap_n_r;
  logic [CNT_W-1:0]   snap_rank_r;
  logic               snap_busy_r;
  logic               snap_last;
  logic               snap_free;
  logic [CNT_W-1:0]   slot;

  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      out_load;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_CAPACITY:      prdata = CFG_DATA_W'(capacity_r);
      REG_SORTED_OUTPUT: prdata = CFG_DATA_W'(sorted_output_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r      <= CAPACITY_RESET;
      sorted_output_r <= SORTED_OUTPUT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CAPACITY:      capacity_r      <= pwdata[5:0];
        REG_SORTED_OUTPUT: sorted_output_r <= pwdata[0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    if (capacity_r == '0) begin
      limit = CNT_W'(1);
    end else if (int'(capacity_r) > int'(MAX_NEIGHBORS)) begin
      limit = CNT_W'(MAX_NEIGHBORS);
    end else begin
      limit = CNT_W'(capacity_r);
    end
  end

  assign n_now = stage_r.query_start ? '0 : fill_r;
  assign full  = (n_now >= limit);

  always_comb begin
    for (int i = 0; i < int'(MAX_NEIGHBORS); i++) begin
      ge[i] = (CNT_W'(i) < n_now) && (kept_dist_r[i] >= stage_r.distance_sq);
    end
  end

  // The list runs from the worst entry in slot 0 towards the nearest; every slot picks
  // its next value from itself, a neighbour or the candidate by the compare flags alone.
  always_comb begin
    for (int i = 0; i < int'(MAX_NEIGHBORS); i++) begin
      kept_idx_nxt[i]  = kept_idx_r[i];
      kept_dist_nxt[i] = kept_dist_r[i];
      if (!full) begin
        if (!ge[i]) begin
          if (i == 0) begin
            kept_idx_nxt[i]  = stage_r.point_index;
            kept_dist_nxt[i] = stage_r.distance_sq;
          end else if (ge[(i + int'(MAX_NEIGHBORS) - 1) % MAX_NEIGHBORS]) begin
            kept_idx_nxt[i]  = stage_r.point_index;
            kept_dist_nxt[i] = stage_r.distance_sq;
          end else begin
            kept_idx_nxt[i]  = kept_idx_r[(i + int'(MAX_NEIGHBORS) - 1) % MAX_NEIGHBORS];
            kept_dist_nxt[i] = kept_dist_r[(i + int'(MAX_NEIGHBORS) - 1) % MAX_NEIGHBORS];
          end
        end
      end else if (kept_dist_r[0] > stage_r.distance_sq) begin
        if ((i + 1 < int'(MAX_NEIGHBORS)) && ge[(i+1) % MAX_NEIGHBORS]) begin
          kept_idx_nxt[i]  = kept_idx_r[(i+1) % MAX_NEIGHBORS];
          kept_dist_nxt[i] = kept_dist_r[(i+1) % MAX_NEIGHBORS];
        end else if (ge[i]) begin
          kept_idx_nxt[i]  = stage_r.point_index;
          kept_dist_nxt[i] = stage_r.distance_sq;
        end
      end
    end
    fill_nxt = full ? n_now : n_now + CNT_W'(1);
  end

  assign out_load  = snap_busy_r && (!out_valid_r || !out_stall);
  assign snap_last = (snap_rank_r == snap_n_r - CNT_W'(1));
  assign snap_free = !snap_busy_r || (out_load && snap_last);
  assign stage_go  = stage_valid_r && (!stage_r.query_end || snap_free);
  assign in_stall  = stage_valid_r && !stage_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stage_valid_r <= 1'b1;
    end else if (stage_go) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (stage_go) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      kept_idx_r  <= kept_idx_nxt;
      kept_dist_r <= kept_dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && stage_r.query_end) begin
      snap_idx_r  <= kept_idx_nxt;
      snap_dist_r <= kept_dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_busy_r <= 1'b0;
      snap_n_r    <= '0;
      snap_rank_r <= '0;
    end else if (stage_go && stage_r.query_end) begin
      snap_busy_r <= 1'b1;
      snap_n_r    <= fill_nxt;
      snap_rank_r <= '0;
    end else if (out_load) begin
      snap_rank_r <= snap_rank_r + CNT_W'(1);
      if (snap_last) begin
        snap_busy_r <= 1'b0;
      end
    end
  end

  assign slot = sorted_output_r ? (snap_n_r - CNT_W'(1) - snap_rank_r) : snap_rank_r;

  always_comb begin
    out_item_nxt.result_index   = snap_idx_r[slot[IDX_W-1:0]];
    out_item_nxt.result_dist_sq = snap_dist_r[slot[IDX_W-1:0]];
    out_item_nxt.result_rank    = RANK_W'(snap_rank_r);
    out_item_nxt.result_count   = COUNT_W'(snap_n_r);
    out_item_nxt.last_result    = snap_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: sv/kncl_checker.sv
`default_nettype none
`include "k_nearest_candidate_list_defines.svh"

module kncl_checker import kncl_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  `KNCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `KNCL_ASSERT_NOW(a_count_nonzero, out_valid, out_item.result_count != '0)
  `KNCL_ASSERT_NOW(a_last_rank, out_valid && out_item.last_result, COUNT_W'(out_item.result_rank) + COUNT_W'(1) == out_item.result_count)
  `KNCL_ASSERT_NEXT(a_rank_step, out_valid && !out_stall && !out_item.last_result, out_valid && (out_item.result_rank == $past(out_item.result_rank) + RANK_W'(1)))

endmodule

bind k_nearest_candidate_list kncl_checker u_kncl_checker (.*);

`default_nettype wire

// File: sim/k_nearest_candidate_list_test.sv
module k_nearest_candidate_list_test;
  import kncl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 800_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  k_nearest_candidate_list dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Predicted neighbour list, held farthest first as the block keeps it.
  logic [INDEX_W-1:0] list_index [KNCL_MAX_NEIGHBORS] = '{default: '0};
  logic [DIST_W-1:0] list_dist [KNCL_MAX_NEIGHBORS] = '{default: '0};
  int unsigned list_len = 0;
  logic [5:0] k_setting = CAPACITY_RESET;
  logic nearest_first = SORTED_OUTPUT_RESET;

  out_item_t expected_neighbors[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned receiver_hold_cycles = 0;
  int unsigned stall_run = 0;
  bit quiet_mode = 1'b0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("k_nearest_candidate_list regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic void merge_candidate(logic [INDEX_W-1:0] idx,
                                          logic [DIST_W-1:0] cand_dist);
    int unsigned lim;
    int unsigned n;
    int unsigned p;
    lim = (k_setting == 0) ? 1 : (k_setting > KNCL_MAX_NEIGHBORS) ? KNCL_MAX_NEIGHBORS : k_setting;
    n = list_len;
    if (n < lim) begin
      p = n;
      while (p > 0 && list_dist[p-1] < cand_dist) begin
        list_index[p] = list_index[p-1];
        list_dist[p] = list_dist[p-1];
        p--;
      end
      list_index[p] = idx;
      list_dist[p] = cand_dist;
      list_len = n + 1;
    end else if (cand_dist < list_dist[0]) begin
      p = 0;
      while (p + 1 < n && list_dist[p+1] >= cand_dist) begin
        list_index[p] = list_index[p+1];
        list_dist[p] = list_dist[p+1];
        p++;
      end
      list_index[p] = idx;
      list_dist[p] = cand_dist;
    end
  endfunction

  function automatic void absorb_candidate(in_item_t it);
    int unsigned n;
    int unsigned slot;
    out_item_t beat;
    if (it.query_start) list_len = 0;
    merge_candidate(it.point_index, it.distance_sq);
    if (it.query_end) begin
      n = list_len;
      for (int unsigned r = 0; r < n; r++) begin
        slot = nearest_first ? (n - 1 - r) : r;
        beat.result_index = list_index[slot];
        beat.result_dist_sq = list_dist[slot];
        beat.result_rank = RANK_W'(r);
        beat.result_count = COUNT_W'(n);
        beat.last_result = (r + 1 == n);
        expected_neighbors.push_back(beat);
      end
    end
  endfunction

  function automatic logic [DIST_W-1:0] random_distance();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DIST_W'($urandom_range(0, 7));
      3: return {16'hFFFF, 32'($urandom)};
      default: return DIST_W'({$urandom, $urandom});
    endcase
  endfunction

  always @(posedge clk) begin
    if (receiver_hold_cycles > 0) begin
      out_stall <= 1'b1;
      receiver_hold_cycles--;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (!quiet_mode && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_run = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_neighbors.size() == 0) begin
        report_mismatch("unexpected beat, index", out_item.result_index, '0);
      end else begin
        want = expected_neighbors.pop_front();
        if (out_item.result_index !== want.result_index)
          report_mismatch("result_index", out_item.result_index, want.result_index);
        if (out_item.result_dist_sq !== want.result_dist_sq)
          report_mismatch("result_dist_sq", out_item.result_dist_sq, want.result_dist_sq);
        if (out_item.result_rank !== want.result_rank)
          report_mismatch("result_rank", out_item.result_rank, want.result_rank);
        if (out_item.result_count !== want.result_count)
          report_mismatch("result_count", out_item.result_count, want.result_count);
        if (out_item.last_result !== want.last_result)
          report_mismatch("last_result", out_item.last_result, want.last_result);
      end
    end
  end

  task automatic send_candidate(logic [INDEX_W-1:0] idx, logic [DIST_W-1:0] cand_dist,
                                logic start, logic last);
    int unsigned gap;
    in_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    gap = quiet_mode ? 0 : (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(6, 20);
    it.point_index = idx;
    it.distance_sq = cand_dist;
    it.query_start = start;
    it.query_end = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_candidate(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_neighbors.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic reg_code, logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_code, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_code == REG_CAPACITY) k_setting = value[5:0];
    else nearest_first = value[0];
    @(posedge clk);
  endtask

  task automatic set_list_mode(int unsigned capacity, bit nearest);
    wait_idle();
    write_register(REG_CAPACITY, CFG_DATA_W'(capacity));
    write_register(REG_SORTED_OUTPUT, CFG_DATA_W'(nearest));
  endtask

  task automatic test_default_mode();
    send_candidate('1, '1, 1'b0, 1'b0);
    send_candidate('0, '0, 1'b0, 1'b0);
    send_candidate(20'h5A5A5, 48'h0000_0001_8000, 1'b0, 1'b1);
  endtask

  task automatic test_single_entry_lists();
    set_list_mode(1, 1'b1);
    send_candidate(20'd7, 48'd100, 1'b1, 1'b0);
    send_candidate(20'd8, 48'd50, 1'b0, 1'b0);
    send_candidate(20'd9, 48'd50, 1'b0, 1'b1);
    set_list_mode(0, 1'b0);
    send_candidate(20'd3, 48'd10, 1'b1, 1'b1);
  endtask

  task automatic test_equal_distances();
    set_list_mode(3, 1'b0);
    send_candidate(20'd1, 48'd5, 1'b1, 1'b0);
    send_candidate(20'd2, 48'd5, 1'b0, 1'b0);
    send_candidate(20'd3, 48'd7, 1'b0, 1'b0);
    send_candidate(20'd4, 48'd7, 1'b0, 1'b0);
    send_candidate(20'd5, 48'd5, 1'b0, 1'b0);
    send_candidate(20'd6, 48'd2, 1'b0, 1'b0);
    send_candidate(20'd7, 48'd5, 1'b0, 1'b1);
  endtask

  task automatic test_capacity_ceiling();
    set_list_mode(63, 1'b1);
    send_candidate(20'd10, 48'd3, 1'b1, 1'b0);
    send_candidate(20'd11, 48'd1, 1'b0, 1'b1);
  endtask

  task automatic test_capacity_lowered_mid_query();
    set_list_mode(6, 1'b1);
    for (int unsigned i = 0; i < 6; i++)
      send_candidate(20'(i + 20), 48'(60 - 10 * i), i == 0, 1'b0);
    set_list_mode(2, 1'b0);
    send_candidate(20'd100, 48'd35, 1'b0, 1'b0);
    send_candidate(20'd101, 48'd70, 1'b0, 1'b1);
  endtask

  task automatic test_list_kept_after_end();
    send_candidate(20'd200, 48'd45, 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    set_list_mode(32, 1'b1);
    quiet_mode = 1'b1;
    receiver_hold_cycles = 300;
    for (int unsigned q = 0; q < 5; q++)
      for (int unsigned i = 0; i < 8; i++)
        send_candidate(20'($urandom), random_distance(), i == 0, i == 7);
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_queries();
    int unsigned sent;
    int unsigned len;
    int unsigned capacity;
    bit with_start;
    logic start;
    logic last;
    sent = 0;
    while (sent < 65) begin
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0: capacity = 0;
          1: capacity = 1;
          2: capacity = 2;
          3: capacity = 32;
          4: capacity = 63;
          5: capacity = $urandom_range(33, 62);
          default: capacity = $urandom_range(3, 31);
        endcase
        set_list_mode(capacity, $urandom_range(0, 1));
      end
      quiet_mode = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 12);
      with_start = ($urandom_range(0, 9) != 0);
      for (int unsigned i = 0; i < len; i++) begin
        start = (i == 0) ? with_start : ($urandom_range(0, 39) == 0);
        last = (i + 1 == len) ? 1'b1 : ($urandom_range(0, 29) == 0);
        send_candidate(20'($urandom), random_distance(), start, last);
      end
      sent += len;
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_mode();
    test_single_entry_lists();
    test_equal_distances();
    test_capacity_ceiling();
    test_capacity_lowered_mid_query();
    test_list_kept_after_end();
    test_backpressure();
    test_random_queries();
    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("k_nearest_candidate_list regression: pass");
    end else begin
      $display("k_nearest_candidate_list regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/kncl_pkg.sv
sv/k_nearest_candidate_list.sv
sv/kncl_checker.sv
sim/k_nearest_candidate_list_test.sv
